// File: design/oaht_pkg.sv
// Shared types and constants of the open-addressing hash table.
// Used by the probe sequencer and by the top level; depends on nothing.
package oaht_pkg;

  localparam int unsigned KEY_W   = 64;
  localparam int unsigned VALUE_W = 64;
  localparam int unsigned HASH_W  = 32;
  localparam int unsigned LIMIT_W = 9;
  localparam int unsigned COUNT_W = 9;
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  localparam logic [1:0] KIND_GET = 2'd0;
  localparam logic [1:0] KIND_SET = 2'd1;
  localparam logic [1:0] KIND_DEL = 2'd2;

  localparam logic [1:0] SLOT_EMPTY = 2'd0;
  localparam logic [1:0] SLOT_LIVE  = 2'd1;
  localparam logic [1:0] SLOT_TOMB  = 2'd2;

  localparam logic REG_OCC_LIMIT = 1'b0;

  localparam logic [LIMIT_W-1:0] OCC_LIMIT_RESET = 9'd192;
  localparam logic [COUNT_W-1:0] COUNT_MAX       = 9'd511;

  typedef struct packed {
    logic               found;
    logic               live;
    logic [VALUE_W-1:0] value;
  } probe_res_t;

endpackage

// File: design/open_addressing_hash_table.sv
// Top level of the open-addressing hash table: slot memories, request sequencer,
// home-slot reduction and APB register. Depends on oaht_pkg and oaht_probe.
//
// A request (kind, key, key_hash, hashable, write_value) is taken on the input
// valid/ready channel and gives exactly one result (status, hit, read_value) on
// the output valid/ready channel. The block works on one request at a time and
// drops in_ready_o until that request is finished.
// A request reduces key_hash to its home slot through a multiply by the
// reciprocal of CAPACITY in states MUL, RED and MOD; MOD starts the probe,
// which visits 1 to CAPACITY slots and hands back its result. EXEC then
// commits and DONE loads the output register. A request that needs no probe
// goes from MOD straight to EXEC. The next request can be taken in the cycle
// after the result is loaded.
// The probe rate is set by the single read port of the slot memories.
// After reset the slot-state memory is cleared one slot per cycle, slots 0 to
// CAPACITY-1, with in_ready_o low; register writes are taken during that pass.
// The result waits in the output register while out_ready_i is low; a request
// finished meanwhile holds its result until the register is free.
// occupancy_limit sits at byte address 0 of the APB port and resets to 192.
module open_addressing_hash_table import oaht_pkg::*; #(
  parameter int unsigned CAPACITY = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         kind_i,
  input  logic [KEY_W-1:0]   key_i,
  input  logic [HASH_W-1:0]  key_hash_i,
  input  logic               hashable_i,
  input  logic [VALUE_W-1:0] write_value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               status_o,
  output logic               hit_o,
  output logic [VALUE_W-1:0] read_value_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int unsigned IDX_W  = $clog2(CAPACITY);
  localparam int unsigned SHIFT  = 31 + IDX_W;
  localparam longint unsigned RECIP = (64'd1 << SHIFT) / CAPACITY;
  localparam logic [31:0] RECIP32 = 32'(RECIP);
  localparam logic [31:0] CAP32   = 32'(CAPACITY);
  localparam logic [IDX_W:0] CAP_X = (IDX_W + 1)'(CAPACITY);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_MUL   = 3'd2;
  localparam logic [2:0] ST_RED   = 3'd3;
  localparam logic [2:0] ST_MOD   = 3'd4;
  localparam logic [2:0] ST_PROBE = 3'd5;
  localparam logic [2:0] ST_EXEC  = 3'd6;
  localparam logic [2:0] ST_DONE  = 3'd7;

  logic [2:0]         state_q, state_d;
  logic [IDX_W-1:0]   clr_q;
  logic [LIMIT_W-1:0] limit_q;
  logic [COUNT_W-1:0] count_q;
  logic               probed_q;
  logic               out_valid_q;

  logic [1:0]         kind_q;
  logic [KEY_W-1:0]   key_q;
  logic [HASH_W-1:0]  hash_q;
  logic               hashable_q;
  logic [VALUE_W-1:0] wval_q;
  logic [63:0]        prod_q;
  logic [31:0]        qd_q;
  logic               res_status_q, res_hit_q;
  logic [VALUE_W-1:0] res_rval_q;
  logic               status_q, hit_q;
  logic [VALUE_W-1:0] rval_q;

  logic [1:0]         slot_mem [CAPACITY];
  logic [KEY_W-1:0]   key_mem [CAPACITY];
  logic [VALUE_W-1:0] val_mem [CAPACITY];
  logic [1:0]         rd_state_q;
  logic [KEY_W-1:0]   rd_key_q;
  logic [VALUE_W-1:0] rd_val_q;

  logic [IDX_W-1:0] rd_addr, p_slot, home, slot_waddr;
  logic             p_busy, p_done, p_start;
  probe_res_t       p_res;

  logic             in_acc, cfg_wr, out_load;
  logic             is_get, is_set, is_del, full, need_probe, lookup_ok, set_go;
  logic             slot_we, kv_we, cnt_inc;
  logic [1:0]       slot_wdata;
  logic             status_d, hit_d;
  logic [VALUE_W-1:0] rval_d;
  logic [31:0]      quot, diff;
  logic [IDX_W:0]   rem1;

  oaht_probe #(
    .CAPACITY (CAPACITY)
  ) u_probe (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (p_start),
    .home_i     (home),
    .key_i      (key_q),
    .rd_state_i (rd_state_q),
    .rd_key_i   (rd_key_q),
    .rd_value_i (rd_val_q),
    .rd_addr_o  (rd_addr),
    .busy_o     (p_busy),
    .done_o     (p_done),
    .slot_o     (p_slot),
    .result_o   (p_res)
  );

  always_comb begin
    in_acc   = in_valid_i && in_ready_o;
    cfg_wr   = psel && penable && pwrite && pready;
    out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

    is_get = (kind_q == KIND_GET);
    is_set = (kind_q == KIND_SET);
    is_del = (kind_q == KIND_DEL);
    full   = ({1'b0, count_q} + 10'd1) > {1'b0, limit_q};
    need_probe = hashable_q && (((is_get || is_del) && (count_q != '0)) ||
                                (is_set && !full));

    quot = 32'(prod_q >> SHIFT);
    diff = hash_q - qd_q;
    rem1 = diff[IDX_W:0];
    home = (rem1 >= CAP_X) ? IDX_W'(rem1 - CAP_X) : rem1[IDX_W-1:0];
    p_start = (state_q == ST_MOD) && need_probe;

    lookup_ok = probed_q && p_res.found && p_res.live;
    set_go    = is_set && probed_q && p_res.found;
    status_d  = is_set && (full || (hashable_q && !p_res.found));
    hit_d     = ((is_get || is_del) && lookup_ok) || (set_go && !p_res.live);
    rval_d    = (is_get && lookup_ok) ? p_res.value : '0;

    kv_we   = (state_q == ST_EXEC) && set_go;
    cnt_inc = kv_we && !p_res.live && (count_q < COUNT_MAX);
    if (state_q == ST_CLEAR) begin
      slot_we    = 1'b1;
      slot_waddr = clr_q;
      slot_wdata = SLOT_EMPTY;
    end else begin
      slot_we    = (state_q == ST_EXEC) && (set_go || (is_del && lookup_ok));
      slot_waddr = p_slot;
      slot_wdata = set_go ? SLOT_LIVE : SLOT_TOMB;
    end

    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (clr_q == IDX_W'(CAPACITY - 1)) state_d = ST_IDLE;
      ST_IDLE:  if (in_valid_i) state_d = ST_MUL;
      ST_MUL:   state_d = ST_RED;
      ST_RED:   state_d = ST_MOD;
      ST_MOD:   state_d = need_probe ? ST_PROBE : ST_EXEC;
      ST_PROBE: if (p_done) state_d = ST_EXEC;
      ST_EXEC:  state_d = ST_DONE;
      ST_DONE:  if (out_load) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  assign in_ready_o   = (state_q == ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign hit_o        = hit_q;
  assign read_value_o = rval_q;
  assign pready       = 1'b1;
  assign prdata       = (paddr[2] == REG_OCC_LIMIT) ? PDATA_W'(limit_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      limit_q     <= OCC_LIMIT_RESET;
      count_q     <= '0;
      probed_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (cfg_wr && (paddr[2] == REG_OCC_LIMIT)) begin
        limit_q <= pwdata[LIMIT_W-1:0];
      end
      if (cnt_inc) begin
        count_q <= count_q + 1'b1;
      end
      if (state_q == ST_MOD) begin
        probed_q <= need_probe;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      kind_q     <= kind_i;
      key_q      <= key_i;
      hash_q     <= key_hash_i;
      hashable_q <= hashable_i;
      wval_q     <= write_value_i;
    end
    if (state_q == ST_MUL) begin
      prod_q <= 64'(hash_q) * 64'(RECIP32);
    end
    if (state_q == ST_RED) begin
      qd_q <= 32'(quot * CAP32);
    end
    if (state_q == ST_EXEC) begin
      res_status_q <= status_d;
      res_hit_q    <= hit_d;
      res_rval_q   <= rval_d;
    end
    if (out_load) begin
      status_q <= res_status_q;
      hit_q    <= res_hit_q;
      rval_q   <= res_rval_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
    rd_state_q <= slot_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (kv_we) begin
      key_mem[p_slot] <= key_q;
      val_mem[p_slot] <= wval_q;
    end
    rd_key_q <= key_mem[rd_addr];
    rd_val_q <= val_mem[rd_addr];
  end

`ifndef SYNTHESIS
  a_count_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q >= $past(count_q))
    else $error("Entry count decreased.");

  a_no_write_while_probing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_busy |-> !slot_we && !kv_we)
    else $error("Slot memory written during a probe.");

  a_done_in_probe_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_done |-> (state_q == ST_PROBE))
    else $error("Probe finished outside the probe state.");

  a_full_never_hits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(status_o && hit_o))
    else $error("Refused request reported a hit.");
`endif

endmodule

// File: design/oaht_probe.sv
// Linear probe sequencer with tombstone tracking and the shared key comparator.
// Depends on oaht_pkg; reads the slot memories held by the top level.
module oaht_probe import oaht_pkg::*; #(
  parameter int unsigned CAPACITY = 256,
  localparam int unsigned IDX_W = $clog2(CAPACITY)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [IDX_W-1:0]   home_i,
  input  logic [KEY_W-1:0]   key_i,
  input  logic [1:0]         rd_state_i,
  input  logic [KEY_W-1:0]   rd_key_i,
  input  logic [VALUE_W-1:0] rd_value_i,
  output logic [IDX_W-1:0]   rd_addr_o,
  output logic               busy_o,
  output logic               done_o,
  output logic [IDX_W-1:0]   slot_o,
  output probe_res_t         result_o
);

  logic             busy_q, data_vld_q, have_tomb_q, done_q;
  logic [IDX_W-1:0] addr_q, data_idx_q, tomb_q, visited_q, slot_q;
  probe_res_t       res_q;

  logic             is_live, is_empty, key_eq, eval, take_tomb, last;
  logic             stop_match, stop_empty, finish, have_tomb_d;
  logic [IDX_W-1:0] tomb_d, slot_d, addr_next;
  probe_res_t       res_d;

  always_comb begin
    is_live     = (rd_state_i == SLOT_LIVE);
    is_empty    = (rd_state_i == SLOT_EMPTY);
    key_eq      = (rd_key_i == key_i);
    eval        = busy_q && data_vld_q;
    take_tomb   = eval && !is_live && !is_empty && !have_tomb_q;
    tomb_d      = take_tomb ? data_idx_q : tomb_q;
    have_tomb_d = have_tomb_q || take_tomb;
    last        = (visited_q == IDX_W'(CAPACITY - 1));
    stop_match  = eval && is_live && key_eq;
    stop_empty  = eval && is_empty;
    finish      = stop_match || stop_empty || (eval && last);
    addr_next   = (addr_q == IDX_W'(CAPACITY - 1)) ? '0 : addr_q + 1'b1;
    if (stop_match || (stop_empty && !have_tomb_q)) begin
      slot_d = data_idx_q;
    end else begin
      slot_d = tomb_d;
    end
    res_d.found = stop_match || stop_empty || have_tomb_d;
    res_d.live  = stop_match;
    res_d.value = rd_value_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      data_vld_q  <= 1'b0;
      have_tomb_q <= 1'b0;
      done_q      <= 1'b0;
      visited_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q      <= 1'b1;
        data_vld_q  <= 1'b0;
        have_tomb_q <= 1'b0;
        visited_q   <= '0;
      end else if (busy_q) begin
        data_vld_q <= 1'b1;
        if (eval) begin
          visited_q   <= visited_q + 1'b1;
          have_tomb_q <= have_tomb_d;
        end
        if (finish) begin
          busy_q     <= 1'b0;
          data_vld_q <= 1'b0;
          done_q     <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      addr_q <= home_i;
    end else if (busy_q) begin
      addr_q     <= addr_next;
      data_idx_q <= addr_q;
      if (eval) begin
        tomb_q <= tomb_d;
      end
      if (finish) begin
        res_q  <= res_d;
        slot_q <= slot_d;
      end
    end
  end

  assign rd_addr_o = addr_q;
  assign busy_o    = busy_q;
  assign done_o    = done_q;
  assign slot_o    = slot_q;
  assign result_o  = res_q;

endmodule
